### rtl/core/plc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned ADDR_W = 6;

   localparam logic [2:0] REG_DISPLAY_ENABLES = 3'd0;
   localparam logic [2:0] REG_BLEND_CONTROL = 3'd1;
   localparam logic [2:0] REG_BLEND_COEFFICIENTS = 3'd2;
   localparam logic [2:0] REG_WINDOW_BOUNDS = 3'd3;
   localparam logic [2:0] REG_WINDOW_INSIDE = 3'd4;
   localparam logic [2:0] REG_WINDOW_OUTSIDE = 3'd5;
   localparam logic [2:0] REG_BACKDROP_COLOR = 3'd6;
   localparam logic [2:0] REG_BG_PRIORITIES = 3'd7;

   localparam logic [2:0] ID_SPRITE = 3'd4;
   localparam logic [2:0] ID_BACKDROP = 3'd5;

   localparam logic [1:0] FX_NONE = 2'd0;
   localparam logic [1:0] FX_ALPHA = 2'd1;
   localparam logic [1:0] FX_BRIGHTEN = 2'd2;
   localparam logic [1:0] FX_DARKEN = 2'd3;

   localparam logic [1:0] SPRITE_SEMI = 2'd1;
   localparam logic [1:0] SPRITE_WINDOW = 2'd2;

   localparam logic [4:0] CHAN_MAX = 5'd31;
   localparam logic [4:0] COEF_MAX = 5'd16;

   typedef struct packed {
      logic [6:0] display_enables;
      logic [13:0] blend_control;
      logic [14:0] blend_coefficients;
      logic [63:0] window_bounds;
      logic [13:0] window_inside;
      logic [13:0] window_outside;
      logic [14:0] backdrop_color;
      logic [7:0] bg_priorities;
   } cfg_type;

   typedef struct packed {
      logic [7:0] line;
      logic [7:0] column;
      logic [3:0][15:0] bg_pixel;
      logic [14:0] sprite_color;
      logic sprite_clear;
      logic [1:0] sprite_mode;
      logic [1:0] sprite_priority;
   } pix_type;

   typedef enum logic [1:0] {
      OP_PASS = 2'd0,
      OP_MIX = 2'd1,
      OP_UP = 2'd2,
      OP_DOWN = 2'd3
   } op_type;

   // selection stage result
   typedef struct packed {
      op_type op;
      logic [14:0] top_col;
      logic [14:0] sec_col;
   } sel_type;

   function automatic logic [4:0] clamp_coef(input logic [4:0] c);
      return (c > COEF_MAX) ? COEF_MAX : c;
   endfunction

endpackage
`default_nettype wire

### rtl/core/plc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module plc_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [5:0] csr_paddr,
   input wire logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready,
   output plc_pkg::cfg_type cfg
);
   import plc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   logic wr;

   assign idx = csr_paddr[5:3];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_DISPLAY_ENABLES: cfg_in.display_enables = csr_pwdata[6:0];
            REG_BLEND_CONTROL: cfg_in.blend_control = csr_pwdata[13:0];
            REG_BLEND_COEFFICIENTS: cfg_in.blend_coefficients = csr_pwdata[14:0];
            REG_WINDOW_BOUNDS: cfg_in.window_bounds = csr_pwdata;
            REG_WINDOW_INSIDE: cfg_in.window_inside = csr_pwdata[13:0];
            REG_WINDOW_OUTSIDE: cfg_in.window_outside = csr_pwdata[13:0];
            REG_BACKDROP_COLOR: cfg_in.backdrop_color = csr_pwdata[14:0];
            default: cfg_in.bg_priorities = csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:0] == 3'd0) begin
         unique case (idx)
            REG_DISPLAY_ENABLES: csr_prdata = {57'd0, cfg_ff.display_enables};
            REG_BLEND_CONTROL: csr_prdata = {50'd0, cfg_ff.blend_control};
            REG_BLEND_COEFFICIENTS: csr_prdata = {49'd0, cfg_ff.blend_coefficients};
            REG_WINDOW_BOUNDS: csr_prdata = cfg_ff.window_bounds;
            REG_WINDOW_INSIDE: csr_prdata = {50'd0, cfg_ff.window_inside};
            REG_WINDOW_OUTSIDE: csr_prdata = {50'd0, cfg_ff.window_outside};
            REG_BACKDROP_COLOR: csr_prdata = {49'd0, cfg_ff.backdrop_color};
            default: csr_prdata = {56'd0, cfg_ff.bg_priorities};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/plc_window.sv
`timescale 1ns / 1ps
`default_nettype none
// stage 1: window mask
module plc_window (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic in_valid,
   input plc_pkg::pix_type in_pix,
   input plc_pkg::cfg_type cfg,
   output logic out_valid,
   output plc_pkg::pix_type out_pix,
   output logic [5:0] out_mask
);
   import plc_pkg::*;

   logic valid_ff;
   pix_type pix_ff;
   logic [5:0] mask_ff, mask_in;
   logic [1:0] hit;
   logic w0, w1, ow, any_en;

   always_comb begin
      for (int w = 0; w < 2; w++) begin
         hit[w] = in_pix.column >= cfg.window_bounds[w*32 +: 8]
            && in_pix.column < cfg.window_bounds[w*32+8 +: 8]
            && in_pix.line >= cfg.window_bounds[w*32+16 +: 8]
            && in_pix.line < cfg.window_bounds[w*32+24 +: 8];
      end
      w0 = cfg.display_enables[4] && hit[0];
      w1 = cfg.display_enables[5] && hit[1];
      ow = cfg.display_enables[6] && in_pix.sprite_mode == SPRITE_WINDOW
         && !in_pix.sprite_clear;
      any_en = |cfg.display_enables[6:4];
      priority if (w0) mask_in = cfg.window_inside[5:0];
      else if (w1) mask_in = cfg.window_inside[13:8];
      else if (ow) mask_in = cfg.window_outside[13:8];
      else if (any_en) mask_in = cfg.window_outside[5:0];
      else mask_in = 6'h3F;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix_ff <= in_pix;
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix = pix_ff;
   assign out_mask = mask_ff;
endmodule
`default_nettype wire

### rtl/core/plc_select.sv
`timescale 1ns / 1ps
`default_nettype none
// stage 2: layer priority and effect decision
module plc_select (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic in_valid,
   input plc_pkg::pix_type in_pix,
   input wire logic [5:0] in_mask,
   input plc_pkg::cfg_type cfg,
   output logic out_valid,
   output plc_pkg::sel_type out_sel
);
   import plc_pkg::*;

   logic valid_ff;
   sel_type sel_ff, sel_in;
   logic [2:0] c0, c1, top_id, sec_id;
   logic [1:0] n;
   logic [3:0] ok;
   logic sprite_vis;
   logic [1:0] fx;

   function automatic logic [1:0] prio_of(input logic [7:0] p, input logic [2:0] id);
      return p[id[1:0]*2 +: 2];
   endfunction

   function automatic logic [14:0] col_of(input logic [2:0] id, input pix_type px,
         input logic [14:0] bd);
      logic [14:0] r;
      if (id == ID_SPRITE) r = px.sprite_color;
      else if (id == ID_BACKDROP) r = bd;
      else r = px.bg_pixel[id[1:0]][14:0];
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ok[i] = cfg.display_enables[i] && in_mask[i] && !in_pix.bg_pixel[i][15];
      end
      c0 = ID_BACKDROP;
      c1 = ID_BACKDROP;
      n = 2'd0;
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 4; i++) begin
            if (ok[i] && cfg.bg_priorities[2*i +: 2] == 2'(p) && n < 2'd2) begin
               if (n == 2'd0) c0 = 3'(i);
               else c1 = 3'(i);
               n = n + 2'd1;
            end
         end
      end
      sprite_vis = !in_pix.sprite_clear && in_pix.sprite_mode != SPRITE_WINDOW && in_mask[4];
      top_id = c0;
      sec_id = c1;
      if (sprite_vis) begin
         if (c0 == ID_BACKDROP
               || prio_of(cfg.bg_priorities, c0) >= in_pix.sprite_priority) begin
            top_id = ID_SPRITE;
            sec_id = c0;
         end else if (c1 == ID_BACKDROP
               || prio_of(cfg.bg_priorities, c1) >= in_pix.sprite_priority) begin
            sec_id = ID_SPRITE;
         end
      end
      fx = cfg.blend_control[7:6];
      sel_in.top_col = col_of(top_id, in_pix, cfg.backdrop_color);
      sel_in.sec_col = col_of(sec_id, in_pix, cfg.backdrop_color);
      sel_in.op = OP_PASS;
      if (top_id == ID_SPRITE && in_pix.sprite_mode == SPRITE_SEMI
            && cfg.blend_control[8 + sec_id]) begin
         sel_in.op = OP_MIX;
      end else if (in_mask[5] && fx != FX_NONE && cfg.blend_control[top_id]) begin
         unique case (fx)
            FX_ALPHA: sel_in.op = cfg.blend_control[8 + sec_id] ? OP_MIX : OP_PASS;
            FX_BRIGHTEN: sel_in.op = OP_UP;
            FX_DARKEN: sel_in.op = OP_DOWN;
            default: sel_in.op = OP_PASS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sel = sel_ff;
endmodule
`default_nettype wire

### rtl/core/plc_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// stages 3 and 4: products, then shift, clamp and widen
module plc_blend (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic in_valid,
   input plc_pkg::sel_type in_sel,
   input plc_pkg::cfg_type cfg,
   output logic out_valid,
   output logic [23:0] out_rgb
);
   import plc_pkg::*;

   logic valid3_ff, valid4_ff;
   op_type op_ff;
   logic [2:0][4:0] col_ff;
   logic [2:0][9:0] pa_ff, pa_in;
   logic [2:0][9:0] pb_ff, pb_in;
   logic [23:0] rgb_ff, rgb_in;
   logic [4:0] w1, w2, f;

   always_comb begin
      w1 = clamp_coef(cfg.blend_coefficients[4:0]);
      w2 = clamp_coef(cfg.blend_coefficients[9:5]);
      f = clamp_coef(cfg.blend_coefficients[14:10]);
      for (int k = 0; k < 3; k++) begin
         logic [4:0] a, b;
         a = in_sel.top_col[5*k +: 5];
         b = in_sel.sec_col[5*k +: 5];
         unique case (in_sel.op)
            OP_MIX: begin
               pa_in[k] = a * w1;
               pb_in[k] = b * w2;
            end
            OP_UP: begin
               pa_in[k] = (CHAN_MAX - a) * f;
               pb_in[k] = '0;
            end
            OP_DOWN: begin
               pa_in[k] = a * f;
               pb_in[k] = '0;
            end
            default: begin
               pa_in[k] = '0;
               pb_in[k] = '0;
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [10:0] s;
         logic [4:0] v;
         s = {1'b0, pa_ff[k]} + {1'b0, pb_ff[k]};
         unique case (op_ff)
            OP_MIX: v = (s[10:4] > 7'(CHAN_MAX)) ? CHAN_MAX : s[8:4];
            OP_UP: v = col_ff[k] + pa_ff[k][8:4];
            OP_DOWN: v = col_ff[k] - pa_ff[k][8:4];
            default: v = col_ff[k];
         endcase
         rgb_in[8*(2-k) +: 8] = {v, v[4:2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (adv) begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= in_sel.op;
         col_ff <= in_sel.top_col;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         rgb_ff <= rgb_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_rgb = rgb_ff;
endmodule
`default_nettype wire

### rtl/core/pixel_layer_compositor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle when not stalled, set by the four-stage
// pipeline (window mask, layer select, products, shift and widen).
// The pipeline stalls as a whole when rsp_tready is low and rsp_tvalid is high.
// Synchronous active-high reset clears the configuration registers and pipeline valid bits.
module pixel_layer_compositor_core #(
   parameter int LINE_WIDTH = 240
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // line, column, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, sprite_color,
   // sprite_clear, sprite_mode, sprite_priority; zero fill
   input wire logic [103:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // pixel_rgb
   output logic [23:0] rsp_tdata,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [5:0] csr_paddr,
   input wire logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   import plc_pkg::*;

   cfg_type cfg;
   pix_type pix, pix1;
   sel_type sel2;
   logic [5:0] mask1;
   logic v1, v2, adv;
   logic [$clog2(LINE_WIDTH+1)-1:0] width_unused;

   assign width_unused = ($clog2(LINE_WIDTH+1))'(LINE_WIDTH);

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign pix.line = req_tdata[7:0];
   assign pix.column = req_tdata[15:8];
   assign pix.bg_pixel[0] = req_tdata[31:16];
   assign pix.bg_pixel[1] = req_tdata[47:32];
   assign pix.bg_pixel[2] = req_tdata[63:48];
   assign pix.bg_pixel[3] = req_tdata[79:64];
   assign pix.sprite_color = req_tdata[94:80];
   assign pix.sprite_clear = req_tdata[95];
   assign pix.sprite_mode = req_tdata[97:96];
   assign pix.sprite_priority = req_tdata[99:98];

   plc_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   plc_window u_window (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid && (width_unused != '0 || 1'b1)), .in_pix(pix), .cfg(cfg),
      .out_valid(v1), .out_pix(pix1), .out_mask(mask1)
   );

   plc_select u_select (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v1), .in_pix(pix1), .in_mask(mask1), .cfg(cfg),
      .out_valid(v2), .out_sel(sel2)
   );

   plc_blend u_blend (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v2), .in_sel(sel2), .cfg(cfg),
      .out_valid(rsp_tvalid), .out_rgb(rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      adv && v1 |=> v2)
      else $error("word lost in select stage");
`endif
endmodule
`default_nettype wire
